### rtl/csm_pkg.sv
// Shared types and constants for the clock step multiplier.
// Used by the controller, the datapath and the top level; no dependencies.
package csm_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_UNITS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLICATION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TRIGGER_GAP  = 2'd2;

  // Field widths fixed by the interface
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned MULT_W  = 8;
  localparam int unsigned COUNT_W = 8;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] UPS_RESET    = 32'd1000;
  localparam logic [MULT_W-1:0]     MULT_RESET   = 8'd2;
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = UPS_RESET * 60 / 120;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 8'd255;

  // Iterations for the remainder division (8 bit by 8 bit product)
  localparam int unsigned SHORT_ITERS = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input beat
    logic prep;       // apply step bookkeeping when the item is a step
    logic div_start;  // launch the divider
    logic div_short;  // remainder division instead of period division
    logic cap_q;      // register the whole-quotient part of the offset
    logic finish;     // commit state and load the result register
    logic sub;        // a sub-step falls due with this item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic armed;       // sub-steps remain
    logic div_busy;    // divider still iterating
    logic since_gt_q;  // time since last sub-step exceeds period / mult
    logic out_free;    // result register can take a beat
  } status_t;

endpackage

### rtl/csm_if.sv
// Handshake channels of the clock step multiplier: input items and results.
// Depends on csm_pkg for the field widths.
interface csm_item_if;
  import csm_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [STAMP_W-1:0] elapsed_time;

  modport source (output valid, mode, elapsed_time, input ready);
  modport sink   (input valid, mode, elapsed_time, output ready);
endinterface

interface csm_result_if;
  import csm_pkg::*;
  logic               valid;
  logic               ready;
  logic               trigger;
  logic [COUNT_W-1:0] buffered;

  modport source (output valid, trigger, buffered, input ready);
  modport sink   (input valid, trigger, buffered, output ready);
endinterface

### rtl/csm_div.sv
// Restoring divider, one quotient bit per cycle, by an 8 bit divisor.
// Depends on csm_pkg; used by the datapath.
module csm_div
  import csm_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              short_run,
  input  logic [W-1:0]      dividend,
  input  logic [MULT_W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quo,
  output logic [MULT_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [MULT_W-1:0] dvsr;
  logic [MULT_W:0]   rem_sh;
  logic              ge;

  assign busy   = (cnt != '0);
  assign rem_sh = {rem, quo[W-1]};
  assign ge     = (rem_sh >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= short_run ? CNT_W'(SHORT_ITERS) : CNT_W'(W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? MULT_W'(rem_sh - {1'b0, dvsr}) : rem_sh[MULT_W-1:0];
    end
  end

endmodule

### rtl/csm_dp.sv
// Datapath: configuration, timing state, offset arithmetic and result register.
// Depends on csm_pkg and csm_div; driven by csm_ctrl through cmd_t.
module csm_dp
  import csm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_mode,
  input  logic [STAMP_W-1:0]    in_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_trigger,
  output logic [COUNT_W-1:0]    out_buffered
);

  localparam int unsigned T     = TIME_BITS;
  localparam int unsigned GAP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  logic [MULT_W-1:0]     mult;
  logic [CFG_DATA_W-1:0] min_gap;
  logic [T-1:0]          step_period;
  logic [T-1:0]          last_step_time;
  logic [T-1:0]          last_substep_time;
  logic [T-1:0]          last_trigger_time;
  logic [COUNT_W-1:0]    substeps_left;
  logic [COUNT_W-1:0]    pending;
  logic                  seen_step;
  logic                  mode_r;
  logic [T-1:0]          now_r;
  logic [T-1:0]          qidx;

  logic [MULT_W-1:0]     m_eff;
  logic [MULT_W-1:0]     idx;
  logic [T-1:0]          since;
  logic [T-1:0]          gap_now;
  logic [COUNT_W+1:0]    prep_sum;
  logic [COUNT_W-1:0]    p1;
  logic                  fire;
  logic [COUNT_W-1:0]    p_final;
  logic [T+MULT_W-1:0]   qprod;
  logic [2*MULT_W-1:0]   rprod;
  logic [T-1:0]          div_dividend;
  logic                  div_busy;
  logic [T-1:0]          div_quo;
  logic [MULT_W-1:0]     div_rem;

  assign m_eff    = (mult == '0) ? MULT_W'(1) : mult;
  assign idx      = m_eff - substeps_left;
  assign since    = now_r - last_substep_time;
  assign gap_now  = now_r - last_trigger_time;
  assign prep_sum = (COUNT_W+2)'(pending) + (COUNT_W+2)'(substeps_left) + (COUNT_W+2)'(1);
  assign qprod    = (T+MULT_W)'(div_quo) * (T+MULT_W)'(idx);
  assign rprod    = (2*MULT_W)'(div_rem) * (2*MULT_W)'(idx);

  // Remainder division sits at the top of the dividend so 16 steps finish it
  assign div_dividend = cmd.div_short ? (T'(rprod) << (T - SHORT_ITERS)) : step_period;

  always_comb begin
    p1 = pending;
    if (cmd.sub && pending != COUNT_MAX) begin
      p1 = pending + COUNT_W'(1);
    end
    fire    = (p1 != '0) && (GAP_W'(gap_now) > GAP_W'(min_gap));
    p_final = fire ? p1 - COUNT_W'(1) : p1;
  end

  assign status.armed      = (substeps_left != '0);
  assign status.div_busy   = div_busy;
  assign status.since_gt_q = (since > div_quo);
  assign status.out_free   = !out_valid || out_ready;

  csm_div #(.W(T)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .short_run (cmd.div_short),
    .dividend  (div_dividend),
    .divisor   (m_eff),
    .busy      (div_busy),
    .quo       (div_quo),
    .rem       (div_rem)
  );

  // Configuration registers; the rate register reloads the step period
  always_ff @(posedge clk) begin
    if (rst) begin
      mult    <= MULT_RESET;
      min_gap <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MULTIPLICATION:  mult    <= cfg_data[MULT_W-1:0];
        REG_MIN_TRIGGER_GAP: min_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      now_r  <= T'(in_time);
    end
    if (cmd.cap_q) begin
      qidx <= qprod[T-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period       <= T'(PERIOD_RESET);
      last_step_time    <= '0;
      last_substep_time <= '0;
      last_trigger_time <= '0;
      substeps_left     <= '0;
      pending           <= '0;
      seen_step         <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_UNITS_PER_SECOND) begin
        step_period <= T'(cfg_data >> 1);
      end else if (cmd.prep && mode_r && seen_step) begin
        step_period <= now_r - last_step_time;
      end
      if (cmd.prep && mode_r) begin
        pending           <= (prep_sum > (COUNT_W+2)'(COUNT_MAX)) ?
                             COUNT_MAX : prep_sum[COUNT_W-1:0];
        substeps_left     <= m_eff - MULT_W'(1);
        last_step_time    <= now_r;
        last_substep_time <= now_r;
        seen_step         <= 1'b1;
      end
      if (cmd.finish) begin
        pending <= p_final;
        if (cmd.sub) begin
          last_substep_time <= last_step_time + qidx + div_quo;
          substeps_left     <= substeps_left - COUNT_W'(1);
        end
        if (fire) begin
          last_trigger_time <= now_r;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_trigger  <= fire;
      out_buffered <= p_final;
    end
  end

endmodule

### rtl/csm_ctrl.sv
// Controller: sequences one item through step update, divisions and commit.
// Depends on csm_pkg; drives csm_dp through cmd_t.
module csm_ctrl
  import csm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_DIV1   = 7'b0001000,
    S_CMP    = 7'b0010000,
    S_DIV2   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   sub_hit, sub_hit_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    sub_hit_next = sub_hit;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        sub_hit_next = 1'b0;
        if (status.armed) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV1: begin
        if (!status.div_busy) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.since_gt_q) begin
          cmd.div_start = 1'b1;
          cmd.div_short = 1'b1;
          cmd.cap_q     = 1'b1;
          sub_hit_next  = 1'b1;
          state_next    = S_DIV2;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV2: begin
        if (!status.div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          cmd.sub    = sub_hit;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sub_hit <= 1'b0;
    end else begin
      state   <= state_next;
      sub_hit <= sub_hit_next;
    end
  end

endmodule

### rtl/clock_step_multiplier.sv
// Clock step multiplier. Each input beat carries a wrapping timestamp and is
// either a time update (mode 0) or an incoming step (mode 1). A step measures
// the period since the previous step, buffers one trigger plus any sub-steps
// still left from the previous step, and arms multiplication-1 sub-steps,
// each of which adds a trigger when its evenly divided point of the period
// has passed. Every input beat yields exactly one result beat: trigger is 1
// when a buffered trigger is released (at most one per item, and only when
// the time since the last release exceeds min_trigger_gap), and buffered is
// the count still waiting, saturating at 255. Items are handled one at a
// time. With sub-steps armed the shared one-bit-per-cycle divider computes
// period / multiplication; when a sub-step falls due it runs again for the
// remainder share of the offset. A finished result sits in an output
// register, so the next item is accepted while it waits; the commit stalls
// only if the previous result is still untaken. Configuration
// (units_per_second, multiplication, min_trigger_gap at indexes 0..2) is to
// be written by the user only while idle; the block itself does not enforce
// it. A units_per_second write reloads the step period with half its value.
// Depends on csm_pkg, csm_if, csm_ctrl and csm_dp.
module clock_step_multiplier
  import csm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  csm_item_if.sink              item,
  csm_result_if.source          result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic    item_ready;

  // Input beats are taken only while the controller is idle
  assign item.ready = item_ready;

  csm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Timing state, divider and result register live in the datapath
  csm_dp #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mode      (item.mode),
    .in_time      (item.elapsed_time),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_trigger  (result.trigger),
    .out_buffered (result.buffered)
  );

endmodule

### rtl/csm_checker.sv
// Port-level checks for the clock step multiplier, bound to the top level.
// Depends on csm_pkg and the channel interfaces of clock_step_multiplier.
module csm_checker
  import csm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_trigger,
  input logic [COUNT_W-1:0] res_buffered
);

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_trigger) && $stable(res_buffered))
    else $error("result payload changed while stalled");

  // One item at a time: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted while an item is in flight");

  // A released trigger always leaves the buffer below saturation
  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_trigger |-> res_buffered != COUNT_MAX)
    else $error("trigger released with a saturated buffer count");

endmodule

bind clock_step_multiplier csm_checker u_csm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_trigger  (result.trigger),
  .res_buffered (result.buffered)
);
